@@ hw/rtl/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, character constants and the symbol lookup for the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

  localparam logic [7:0] CharPad   = 8'h3D;  // '='
  localparam logic [7:0] CharDash  = 8'h2D;  // '-', URL form of '+'
  localparam logic [7:0] CharUnder = 8'h5F;  // '_', URL form of '/'
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [5:0] ValPlus   = 6'd62;
  localparam logic [5:0] ValSlash  = 6'd63;

  // One queue entry: everything one input beat produces.
  typedef struct packed {
    logic [7:0] byte1;
    logic [7:0] byte0;
    logic [1:0] nbytes;  // 0..2 decoded bytes
    logic       fin;     // last beat of the stream
    logic       err;     // error flag after this beat
  } b64d_entry_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] val;
  } b64d_sym_t;

  function automatic b64d_sym_t sym_decode(input logic [7:0] c);
    b64d_sym_t  r;
    logic [7:0] d;
    r = '0;
    d = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      r = '{valid: 1'b1, val: d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'd71;
      r = '{valid: 1'b1, val: d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'd4;
      r = '{valid: 1'b1, val: d[5:0]};
    end else if (c == CharPlus || c == CharDash) begin
      r = '{valid: 1'b1, val: ValPlus};
    end else if (c == CharSlash || c == CharUnder) begin
      r = '{valid: 1'b1, val: ValSlash};
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CharSpace) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/base64_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder, standard and URL alphabets, one char per beat.
// ----------------------------------------------------------------------------
// Path: a result beat is written into the queue at the edge that accepts its
//   input beat, then loaded into the output register once it is at the queue
//   head and the output register is free.
// Throughput: one input beat per cycle unless the queue is full, one output
//   beat per cycle while the receiver is ready; a character releasing two
//   bytes takes two output beats, which the queue of FifoDepth entries absorbs.
// Reset: rst_ni clears decode state, queue and output valid; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder #(
  parameter int FifoDepth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input stream
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  wire logic       s_axis_tlast,   // final_req
  // output stream
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] data_byte
  output logic [1:0]      m_axis_tuser,   // [0] has_data, [1] bad_input
  output logic            m_axis_tlast    // stream_end
);
  import b64d_pkg::*;

  logic        accept;
  logic        push;
  logic        full;
  logic        pop;
  logic        head_valid;
  b64d_entry_t entry;
  b64d_entry_t head;

  // Front only stalls when the queue is full; the output side never
  // backs up directly into the input.
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Front: whitespace skip, alphabet lookup, group assembly, pad and error
  // tracking, hold of the first byte until the stream proves long enough.
  b64d_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .symbol_i (s_axis_tdata),
    .final_i  (s_axis_tlast),
    .push_o   (push),
    .entry_o  (entry)
  );

  // Queue of per-beat results (0..2 bytes, end and error flags).
  b64d_fifo #(
    .Depth (FifoDepth),
    .Width ($bits(b64d_entry_t))
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (head),
    .valid_o (head_valid)
  );

  // Back: serializes each entry into one or two output beats.
  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_o    (m_axis_tdata),
    .m_tuser_o    (m_axis_tuser),
    .m_tlast_o    (m_axis_tlast)
  );

  // A beat without data only marks a stream end or a fresh error.
  a_empty_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast || m_axis_tuser[1])
    else $error("empty result beat without end or error");

  // Decoded bytes never travel with the error flag.
  a_bytes_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && entry.nbytes != 2'd0 |-> !entry.err)
    else $error("bytes queued after an error");

  // At most two bytes per character, and empty entries need a reason.
  a_entry_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> entry.nbytes != 2'd3 && (entry.nbytes != 2'd0 || entry.fin || entry.err))
    else $error("malformed queue entry");

endmodule

`default_nettype wire

@@ hw/rtl/b64d_front.sv @@
// ----------------------------------------------------------------------------
// b64d_front
// Classifies each character, advances the group state, builds a queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic [7:0]           symbol_i,
  input  wire logic                 final_i,
  output logic                      push_o,
  output b64d_pkg::b64d_entry_t     entry_o
);
  import b64d_pkg::*;

  logic [5:0] left_q, left_d;
  logic [1:0] pos_q, pos_d;
  logic [1:0] cnt_q, cnt_d;
  logic [7:0] held_q, held_d;
  logic       held_vld_q, held_vld_d;
  logic [1:0] pad_q, pad_d;
  logic       err_q, err_d;

  b64d_sym_t  sym;
  logic       new_err;
  logic       have;
  logic [7:0] b;
  logic [1:0] nb;
  logic [7:0] b0, b1;

  always_comb begin
    sym        = sym_decode(symbol_i);
    left_d     = left_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    pad_d      = pad_q;
    err_d      = err_q;
    new_err    = 1'b0;
    have       = 1'b0;
    b          = '0;
    nb         = '0;
    b0         = '0;
    b1         = '0;

    if (!is_space(symbol_i) && !err_q) begin
      if (cnt_q != 2'd3) cnt_d = cnt_q + 2'd1;
      if (symbol_i == CharPad) begin
        if (pad_q >= 2'd2) begin
          err_d   = 1'b1;
          new_err = 1'b1;
        end else begin
          pad_d = pad_q + 2'd1;
        end
      end else if (!sym.valid || pad_q != 2'd0) begin
        err_d   = 1'b1;
        new_err = 1'b1;
      end else begin
        unique case (pos_q)
          2'd0: left_d = sym.val;
          2'd1: begin
            b      = {left_q, sym.val[5:4]};
            left_d = {2'b00, sym.val[3:0]};
            have   = 1'b1;
          end
          2'd2: begin
            b      = {left_q[3:0], sym.val[5:2]};
            left_d = {4'b0000, sym.val[1:0]};
            have   = 1'b1;
          end
          default: begin
            b      = {left_q[1:0], sym.val};
            left_d = '0;
            have   = 1'b1;
          end
        endcase
        pos_d = pos_q + 2'd1;
        if (have) begin
          if (cnt_d != 2'd3) begin
            held_d     = b;
            held_vld_d = 1'b1;
          end else if (held_vld_q) begin
            b0         = held_q;
            b1         = b;
            nb         = 2'd2;
            held_vld_d = 1'b0;
          end else begin
            b0 = b;
            nb = 2'd1;
          end
        end
      end
      // held first byte comes out once the third significant char is seen
      if (!err_d && cnt_d == 2'd3 && held_vld_d) begin
        b0         = held_d;
        nb         = 2'd1;
        held_vld_d = 1'b0;
      end
    end

    if (final_i) begin
      left_d     = '0;
      pos_d      = '0;
      cnt_d      = '0;
      held_d     = '0;
      held_vld_d = 1'b0;
      pad_d      = '0;
      err_d      = 1'b0;
    end
  end

  assign push_o  = accept_i && (nb != 2'd0 || final_i || new_err);
  assign entry_o = '{byte1: b1, byte0: b0, nbytes: nb, fin: final_i,
                     err: err_q | new_err};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q     <= '0;
      pos_q      <= '0;
      cnt_q      <= '0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
      pad_q      <= '0;
      err_q      <= 1'b0;
    end else if (accept_i) begin
      left_q     <= left_d;
      pos_q      <= pos_d;
      cnt_q      <= cnt_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      pad_q      <= pad_d;
      err_q      <= err_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/b64d_fifo.sv @@
// ----------------------------------------------------------------------------
// b64d_fifo
// Small register queue between front and back, head visible without a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_fifo #(
  parameter int Depth = 4,
  parameter int Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  valid_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
      if (pop_i)  rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/b64d_back.sv @@
// ----------------------------------------------------------------------------
// b64d_back
// Splits each queue entry into output beats and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  head_valid_i,
  input  wire b64d_pkg::b64d_entry_t head_i,
  output logic                       pop_o,
  output logic                       m_tvalid_o,
  input  wire logic                  m_tready_i,
  output logic [7:0]                 m_tdata_o,
  output logic [1:0]                 m_tuser_o,
  output logic                       m_tlast_o
);
  import b64d_pkg::*;

  logic       idx_q;
  logic       vld_q;
  logic [7:0] data_q;
  logic [1:0] user_q;
  logic       last_q;
  logic       load;
  logic       last_of_entry;

  // second beat only exists when the entry carries two bytes
  assign last_of_entry = idx_q || (head_i.nbytes != 2'd2);
  assign load          = head_valid_i && (!vld_q || m_tready_i);
  assign pop_o         = load && last_of_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        idx_q <= !last_of_entry;
      end else if (m_tready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= idx_q ? head_i.byte1 : head_i.byte0;
      user_q <= {head_i.err, head_i.nbytes != 2'd0};
      last_q <= head_i.fin && last_of_entry;
    end
  end

  assign m_tvalid_o = vld_q;
  assign m_tdata_o  = data_q;
  assign m_tuser_o  = user_q;
  assign m_tlast_o  = last_q;

endmodule

`default_nettype wire

@@ dv/tb_base64_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder
// Self-checking bench for the streaming base64 decoder.
// ----------------------------------------------------------------------------
// A directed table covers the extremes, both alphabets, whitespace, padding,
// short streams and every error path. Random streams follow: mostly
// well-formed text with random content, plus noise, broken and short streams.
// Every accepted input beat runs through a local decoder model. The model's
// output beats are queued and compared with each accepted output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_base64_stream_decoder;

  // Cycles with no beat on either side before the run is declared hung.
  localparam int QuietLimit = 4000;
  // Cycles kept open after the last expected beat, for stray output.
  localparam int DrainCycles = 10;
  // Input characters (whitespace included) in the random part.
  localparam int RandChars = 400;

  // One output beat as seen on the master side.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       bad_input;
    logic       stream_end;
  } out_beat_t;

  // One input beat. When typed is set, res is the single expected beat
  // written by hand; otherwise the model supplies the expectation.
  typedef struct packed {
    logic [7:0] sym;
    logic       last;
    logic       typed;
    out_beat_t  res;
  } stim_row_t;

  // Decoder state kept by the bench.
  typedef struct packed {
    logic [5:0] rem_bits;       // low bits of the previous character
    logic [1:0] grp_pos;        // position within the 4-char group
    logic [1:0] sig_cnt;        // significant chars seen, sticks at 3
    logic [7:0] first_byte;     // first byte, held back for short streams
    logic       first_pending;
    logic [1:0] pads;           // '=' seen so far
    logic       failed;         // error latched for the rest of the stream
  } dec_state_t;

  localparam out_beat_t NoRes = '0;

  // Directed beats. Typed rows: right after reset, byte extremes, error codes
  // and short/empty streams.
  localparam stim_row_t DirTbl [25] = '{
    '{8'h21, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},  // '!' alone: bad, end
    '{8'h54, 1'b0, 1'b0, NoRes},                       // "TWFu" -> "Man"
    '{8'h57, 1'b0, 1'b0, NoRes},
    '{8'h46, 1'b0, 1'b0, NoRes},                       // releases two bytes
    '{8'h75, 1'b1, 1'b0, NoRes},
    '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},  // low extreme: error
    '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},  // high extreme, ignored
    '{8'h20, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}},  // empty stream
    '{8'h51, 1'b0, 1'b0, NoRes},                       // "QQ": held byte dropped
    '{8'h51, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}},
    '{8'h2D, 1'b0, 1'b0, NoRes},                       // URL alphabet, with
    '{8'h09, 1'b0, 1'b0, NoRes},                       // TAB and CR skipped
    '{8'h5F, 1'b0, 1'b0, NoRes},
    '{8'h2D, 1'b0, 1'b0, NoRes},
    '{8'h0D, 1'b0, 1'b0, NoRes},
    '{8'h5F, 1'b1, 1'b0, NoRes},
    '{8'h51, 1'b0, 1'b0, NoRes},                       // "QQ==": pad releases
    '{8'h51, 1'b0, 1'b0, NoRes},                       // the held byte
    '{8'h3D, 1'b0, 1'b0, NoRes},
    '{8'h3D, 1'b0, 1'b0, NoRes},
    '{8'h3D, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},  // third pad: error
    '{8'h7A, 1'b1, 1'b0, NoRes},
    '{8'h3D, 1'b0, 1'b0, NoRes},                       // data after a pad
    '{8'h41, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
    '{8'h39, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // [7:0] symbol
  logic       s_axis_tlast = 1'b0; // final_req
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [7:0] data_byte
  logic [1:0] m_axis_tuser;        // [0] has_data, [1] bad_input
  logic       m_axis_tlast;        // stream_end

  stim_row_t  cur_row = '0;        // row currently on the slave side
  dec_state_t dec_st = '0;
  out_beat_t  exp_beats [$];
  int         mismatches = 0;
  int         quiet_cycles = 0;
  int         idle_pct = 0;        // sender gap odds, percent
  int         stall_pct = 0;       // receiver stall odds, percent
  int         chars_sent = 0;

  base64_stream_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Character classes
  // --------------------------------------------------------------------------
  function automatic logic is_blank(input logic [7:0] c);
    return c == b64d_pkg::CharSpace || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // {not_a_symbol, 6-bit value}
  function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
    logic [7:0] v;
    v = '0;
    if (c >= "A" && c <= "Z") v = c - "A";
    else if (c >= "a" && c <= "z") v = c - "a" + 8'd26;
    else if (c >= "0" && c <= "9") v = c - "0" + 8'd52;
    else if (c == b64d_pkg::CharPlus || c == b64d_pkg::CharDash)
      v = 8'(b64d_pkg::ValPlus);
    else if (c == b64d_pkg::CharSlash || c == b64d_pkg::CharUnder)
      v = 8'(b64d_pkg::ValSlash);
    else return {1'b1, 6'd0};
    return {1'b0, v[5:0]};
  endfunction

  // --------------------------------------------------------------------------
  // Decoder model: one input character in, up to two output beats out.
  // --------------------------------------------------------------------------
  function automatic void decode_char(input logic [7:0] sym, input logic last,
                                      output out_beat_t res [3], output int n);
    logic [7:0] bytes [2];
    logic [6:0] sx;
    logic [7:0] b;
    logic       have;
    logic       new_err;
    int         nb;
    nb = 0;
    new_err = 1'b0;
    b = '0;
    have = 1'b0;
    if (!is_blank(sym) && !dec_st.failed) begin
      sx = char_to_sextet(sym);
      if (dec_st.sig_cnt != 2'd3) dec_st.sig_cnt++;
      if (sym == b64d_pkg::CharPad) begin
        if (dec_st.pads == 2'd2) begin
          dec_st.failed = 1'b1;
          new_err = 1'b1;
        end else begin
          dec_st.pads++;
        end
      end else if (sx[6] || dec_st.pads != 0) begin
        // bad character, or data after a pad
        dec_st.failed = 1'b1;
        new_err = 1'b1;
      end else begin
        case (dec_st.grp_pos)
          2'd0: dec_st.rem_bits = sx[5:0];
          2'd1: begin
            b = {dec_st.rem_bits, sx[5:4]};
            dec_st.rem_bits = {2'b00, sx[3:0]};
            have = 1'b1;
          end
          2'd2: begin
            b = {dec_st.rem_bits[3:0], sx[5:2]};
            dec_st.rem_bits = {4'b0000, sx[1:0]};
            have = 1'b1;
          end
          default: begin
            b = {dec_st.rem_bits[1:0], sx[5:0]};
            dec_st.rem_bits = '0;
            have = 1'b1;
          end
        endcase
        dec_st.grp_pos++;
        if (have) begin
          if (dec_st.sig_cnt != 2'd3) begin
            dec_st.first_byte = b;
            dec_st.first_pending = 1'b1;
          end else begin
            // held byte goes out ahead of this beat's own byte
            if (dec_st.first_pending) begin
              bytes[nb] = dec_st.first_byte;
              nb++;
              dec_st.first_pending = 1'b0;
            end
            bytes[nb] = b;
            nb++;
          end
        end
      end
      // a third significant char that makes no byte (a pad) still releases
      if (!dec_st.failed && dec_st.sig_cnt == 2'd3 && dec_st.first_pending) begin
        bytes[nb] = dec_st.first_byte;
        nb++;
        dec_st.first_pending = 1'b0;
      end
    end
    n = (nb == 0 && (last || new_err)) ? 1 : nb;
    for (int k = 0; k < 3; k++) begin
      res[k] = '0;
      if (k < nb) begin
        res[k].data_byte = bytes[k];
        res[k].has_data = 1'b1;
      end
      res[k].stream_end = last && (k == n - 1);
      res[k].bad_input = dec_st.failed;
    end
    if (last) dec_st = '0;
  endfunction

  function automatic void check_field(input string name, input int want,
                                      input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: predicts on every accepted input beat, checks every accepted
  // output beat, and runs the hang watchdog. Sampling at the rising edge
  // sees pre-edge values on both sides.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_beat_t pred [3];
    out_beat_t want;
    int        n;
    if (rst_ni) begin
      quiet_cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        quiet_cycles = 0;
        decode_char(cur_row.sym, cur_row.last, pred, n);
        if (cur_row.typed) exp_beats.push_back(cur_row.res);
        else for (int k = 0; k < n; k++) exp_beats.push_back(pred[k]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        quiet_cycles = 0;
        if (exp_beats.size() == 0) begin
          $error("unexpected output beat: data %0h user %0h last %0b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatches++;
        end else begin
          want = exp_beats.pop_front();
          check_field("data_byte", want.data_byte, m_axis_tdata);
          check_field("has_data", want.has_data, m_axis_tuser[0]);
          check_field("bad_input", want.bad_input, m_axis_tuser[1]);
          check_field("stream_end", want.stream_end, m_axis_tlast);
        end
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk_i) begin
    m_axis_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  // --------------------------------------------------------------------------
  // Sender: enters and leaves at a falling edge. Valid is written once per
  // step, so back-to-back beats keep it high.
  // --------------------------------------------------------------------------
  task automatic send_beat(input stim_row_t row);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= row.sym;
    s_axis_tlast  <= row.last;
    cur_row       <= row;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_b64_char();
    int idx;
    idx = $urandom_range(0, 63);
    if (idx < 26) return 8'h41 + 8'(idx);
    if (idx < 52) return 8'h61 + 8'(idx - 26);
    if (idx < 62) return 8'h30 + 8'(idx - 52);
    if (idx == 62)
      return ($urandom_range(0, 2) == 0) ? b64d_pkg::CharDash : b64d_pkg::CharPlus;
    return ($urandom_range(0, 2) == 0) ? b64d_pkg::CharUnder : b64d_pkg::CharSlash;
  endfunction

  function automatic logic [7:0] rand_blank();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? b64d_pkg::CharSpace : 8'd9 + 8'(k);
  endfunction

  // One random stream. Mostly well-formed text with optional padding and
  // whitespace; the rest is noise, broken text or very short streams.
  task automatic send_random_stream();
    logic [7:0] chars [$];
    stim_row_t  row;
    int         kind;
    int         len;
    int         npad;
    kind = $urandom_range(0, 19);
    if (kind < 14 || kind == 16 || kind == 17) begin
      len = (kind < 14) ? $urandom_range(0, 14) : $urandom_range(2, 10);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 5) == 0) chars.push_back(rand_blank());
        chars.push_back(rand_b64_char());
      end
      npad = 0;
      if (len % 4 == 2) npad = $urandom_range(0, 2);
      else if (len % 4 == 3) npad = $urandom_range(0, 1);
      for (int i = 0; i < npad; i++) chars.push_back(b64d_pkg::CharPad);
      if (kind >= 16) begin
        // broken: stray byte or misplaced pad, or a run of three pads
        if ($urandom_range(0, 2) == 0) begin
          repeat (3) chars.push_back(b64d_pkg::CharPad);
        end else begin
          chars.insert($urandom_range(0, chars.size()),
                       ($urandom_range(0, 1) == 0) ? b64d_pkg::CharPad
                                                   : 8'($urandom_range(0, 255)));
        end
      end
    end else if (kind < 16) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      len = $urandom_range(1, 2);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 3) == 0) chars.push_back(rand_blank());
        chars.push_back(($urandom_range(0, 4) == 0) ? b64d_pkg::CharPad
                                                    : rand_b64_char());
      end
    end
    if (chars.size() == 0) chars.push_back(rand_blank());
    foreach (chars[i]) begin
      row = '0;
      row.sym = chars[i];
      row.last = (i == chars.size() - 1);
      chars_sent++;
      send_beat(row);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DirTbl[i]) send_beat(DirTbl[i]);

    // Four traffic phases of about 100 chars each: clean, sender gaps,
    // receiver stalls, light gaps on both sides.
    while (chars_sent < RandChars) begin
      case ((chars_sent / (RandChars / 4)) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      send_random_stream();
    end
    s_axis_tvalid <= 1'b0;

    // the watchdog covers a beat that never shows up
    while (exp_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && exp_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_front.sv
hw/rtl/b64d_fifo.sv
hw/rtl/b64d_back.sv
hw/rtl/base64_stream_decoder.sv
dv/tb_base64_stream_decoder.sv
